FILE: src/fvn_pkg.sv
`default_nettype none
package fvn_pkg;

  localparam int unsigned FIELD_W = 12;
  localparam int unsigned SUM_W   = 24;
  localparam int unsigned FADE_W  = 17;
  localparam int unsigned NUM_W   = 41;
  localparam int unsigned QUO_W   = 8;
  localparam int unsigned CELL_LAT = 5;
  localparam int unsigned POST_LAT = 3;

  localparam logic [31:0] HASH_MUL = 32'h6C078965;
  localparam logic [31:0] X_MUL    = 32'd2971902361;
  localparam logic [31:0] Y_MUL    = 32'd3572953751;
  localparam logic [63:0] COS_STEP = 64'd1073660973;
  localparam logic [63:0] ONE_Q30  = 64'd1073741824;

  typedef enum logic [1:0] {
    CFG_OCTAVES,
    CFG_LEVELS,
    CFG_GAIN,
    CFG_SEED
  } fvn_cfg_e;

  typedef logic [255:0][FADE_W-1:0] fade_tab_t;

  // word moving down the octave chain
  typedef struct packed {
    logic               valid;
    logic [FIELD_W-1:0] x;
    logic [FIELD_W-1:0] y;
    logic [SUM_W-1:0]   sum;
  } fvn_bus_t;

  // word moving down the divider chain
  typedef struct packed {
    logic             valid;
    logic [NUM_W-1:0] rem;
    logic [QUO_W-1:0] quo;
  } fvn_div_t;

  // cosine fade via integer Chebyshev recurrence, mirrored about the center
  function automatic fade_tab_t fade_build();
    logic [63:0] prev;
    logic [63:0] cur;
    logic [63:0] nxt;
    logic [63:0] twice;
    fade_tab_t   t;
    t    = '0;
    prev = ONE_Q30;
    cur  = COS_STEP;
    for (int k = 1; k < 128; k++) begin
      t[k]  = FADE_W'((ONE_Q30 - cur + 64'd16384) >> 15);
      twice = (64'd2 * COS_STEP * cur + (64'd1 << 29)) >> 30;
      nxt   = (twice > prev) ? twice - prev : 64'd0;
      prev  = cur;
      cur   = (nxt > ONE_Q30) ? ONE_Q30 : nxt;
    end
    t[128] = FADE_W'(32768);
    for (int k = 129; k < 256; k++) begin
      t[k] = FADE_W'(65536) - t[256-k];
    end
    return t;
  endfunction

  localparam fade_tab_t FADE = fade_build();

endpackage
`default_nettype wire

FILE: src/fractal_value_noise_pixel.sv
// channel   | ports                              | handshake
// ----------+------------------------------------+--------------------------
// pixel in  | pixel_x_i, pixel_y_i               | start_i, busy_o (always low)
// gray out  | gray_level_o                       | done_o, one-cycle strobe
// config    | cfg_idx_i, cfg_wdata_i             | cfg_we_i, no wait
//
// One pixel enters every cycle; each result passes through five stages per octave
// cell, three posterize and contrast stages and an eight-stage restoring divider.
// Reset clears the pipeline valid bits and loads the register defaults.
// The receiver cannot stall, so nothing ever holds the pipeline.
`default_nettype none
module fractal_value_noise_pixel
  import fvn_pkg::*;
#(
  parameter int unsigned MAX_OCTAVES = 8,
  parameter int unsigned COORD_BITS  = 12
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  output logic                    busy_o,
  input  wire logic [FIELD_W-1:0] pixel_x_i,
  input  wire logic [FIELD_W-1:0] pixel_y_i,
  output logic                    done_o,
  output logic [7:0]              gray_level_o,
  input  wire logic               cfg_we_i,
  input  wire logic [1:0]         cfg_idx_i,
  input  wire logic [31:0]        cfg_wdata_i
);

  localparam int unsigned CW = (COORD_BITS < FIELD_W) ? COORD_BITS : FIELD_W;
  localparam logic [FIELD_W-1:0] CMASK = FIELD_W'((32'd1 << CW) - 32'd1);
  localparam int unsigned LAT = CELL_LAT * MAX_OCTAVES + POST_LAT + QUO_W;

  logic [3:0]  octaves_q;
  logic [7:0]  levels_q;
  logic [11:0] gain_q;
  logic [31:0] seed_q;
  logic [3:0]  oct_eff;
  logic [7:0]  lv_eff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      octaves_q <= 4'd4;
      levels_q  <= 8'd1;
      gain_q    <= 12'd256;
      seed_q    <= '0;
    end else if (cfg_we_i) begin
      unique case (fvn_cfg_e'(cfg_idx_i))
        CFG_OCTAVES: octaves_q <= cfg_wdata_i[3:0];
        CFG_LEVELS:  levels_q  <= cfg_wdata_i[7:0];
        CFG_GAIN:    gain_q    <= cfg_wdata_i[11:0];
        CFG_SEED:    seed_q    <= cfg_wdata_i;
        default:     ;
      endcase
    end
  end

  always_comb begin
    priority if (octaves_q == 4'd0) begin
      oct_eff = 4'd1;
    end else if (octaves_q > 4'(MAX_OCTAVES)) begin
      oct_eff = 4'(MAX_OCTAVES);
    end else begin
      oct_eff = octaves_q;
    end
    lv_eff = (levels_q == 8'd0) ? 8'd1 : levels_q;
  end

  assign busy_o = 1'b0;

  fvn_bus_t bus [MAX_OCTAVES+1];

  assign bus[0].valid = start_i;
  assign bus[0].x     = pixel_x_i & CMASK;
  assign bus[0].y     = pixel_y_i & CMASK;
  assign bus[0].sum   = '0;

  for (genvar g = 0; g < MAX_OCTAVES; g++) begin : g_oct
    fvn_octave_cell #(.IDX(g)) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .octaves_i (oct_eff),
      .seed_i    (seed_q),
      .bus_i     (bus[g]),
      .bus_o     (bus[g+1])
    );
  end

  // posterize and contrast
  logic             v1_q, v2_q, v3_q;
  logic [31:0]      p_q;
  logic [7:0]       lq_q;
  logic             neg;
  logic             neg_q;
  logic [SUM_W-1:0] mag;
  logic [35:0]      prod_q;
  logic [27:0]      m_raw;
  logic [24:0]      m_clip;
  logic [24:0]      dnew;
  logic [32:0]      level_val;
  logic [NUM_W-1:0] num_q;

  always_comb begin
    neg    = (p_q[23:0] < 24'h800000);
    mag    = neg ? 24'h800000 - p_q[23:0] : p_q[23:0] - 24'h800000;
    m_raw  = prod_q[35:8];
    m_clip = (m_raw > 28'h1000000) ? 25'h1000000 : m_raw[24:0];
    if (neg_q) begin
      dnew = (m_clip > 25'h0800000) ? 25'd0 : 25'h0800000 - m_clip;
    end else begin
      dnew = 25'h0800000 + m_clip;
      if (dnew > 25'h1000000) begin
        dnew = 25'h1000000;
      end
    end
    level_val = {1'b0, lq_q, 24'd0} + 33'(dnew);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= bus[MAX_OCTAVES].valid;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    p_q    <= 32'(bus[MAX_OCTAVES].sum) * 32'(lv_eff);
    prod_q <= 36'(mag) * 36'(gain_q);
    neg_q  <= neg;
    lq_q   <= p_q[31:24];
    num_q  <= NUM_W'(level_val) * NUM_W'(255);
  end

  // divide by level_count * 2^24, one quotient bit per cell
  logic [31:0] den;
  fvn_div_t    dv [QUO_W+1];

  assign den         = {lv_eff, 24'd0};
  assign dv[0].valid = v3_q;
  assign dv[0].rem   = num_q;
  assign dv[0].quo   = '0;

  for (genvar g = 0; g < QUO_W; g++) begin : g_div
    fvn_div_cell #(.BIT(QUO_W - 1 - g)) u_div (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .den_i  (den),
      .div_i  (dv[g]),
      .div_o  (dv[g+1])
    );
  end

  assign done_o       = dv[QUO_W].valid;
  assign gray_level_o = dv[QUO_W].quo;

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(rst_ni, LAT) |-> (done_o == $past(start_i, LAT)))
    else $error("result strobe out of step with accepted pixels");

  a_levels: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lv_eff != 8'd0)
    else $error("zero posterize levels reached the divider");

  a_octaves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (oct_eff != 4'd0) && (oct_eff <= 4'(MAX_OCTAVES)))
    else $error("octave count outside the chain");

endmodule
`default_nettype wire

FILE: src/fvn_octave_cell.sv
`default_nettype none
module fvn_octave_cell
  import fvn_pkg::*;
#(
  parameter int unsigned IDX = 0
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic [3:0]  octaves_i,
  input  wire logic [31:0] seed_i,
  input  wire fvn_bus_t    bus_i,
  output fvn_bus_t         bus_o
);

  localparam logic [3:0] J = 4'(IDX + 1);

  logic        active;
  logic [3:0]  sh;
  logic [31:0] side;
  logic [31:0] x0, y0, x1, y1;
  logic [FIELD_W-1:0] dx, dy;
  logic [FIELD_W+7:0] fxw, fyw;

  // stage 0 -> 1
  fvn_bus_t          b1_q, b2_q, b3_q, b4_q;
  logic [4:1]        act_q;
  logic [31:0]       mx0_q, mx1_q, my0_q, my1_q;
  logic [FADE_W-1:0] fx1_q, fy1_q, fx2_q, fy2_q, fx3_q;
  logic [31:0]       h1, h2, h3, h4;
  logic [SUM_W-1:0]  z1_q, z2_q, z3_q, z4_q;
  logic [NUM_W-1:0]  la_q, lb_q, ra_q, rb_q, pl_q, pr_q;
  logic [NUM_W:0]    lsum, rsum, bsum;
  logic [SUM_W-1:0]  left, right, blended;
  logic [FADE_W-1:0] fx_inv, fy_inv;

  always_comb begin
    active = (J <= octaves_i);
    sh     = octaves_i - J;
    side   = 32'd1 << sh;
    dx     = bus_i.x & FIELD_W'(side - 32'd1);
    dy     = bus_i.y & FIELD_W'(side - 32'd1);
    x0     = {20'd0, bus_i.x - dx};
    y0     = {20'd0, bus_i.y - dy};
    x1     = x0 + side;
    y1     = y0 + side;
    fxw    = {dx, 8'd0} >> sh;
    fyw    = {dy, 8'd0} >> sh;
  end

  always_ff @(posedge clk_i) begin
    mx0_q <= x0 * X_MUL;
    mx1_q <= x1 * X_MUL;
    my0_q <= y0 * Y_MUL;
    my1_q <= y1 * Y_MUL;
    fx1_q <= FADE[fxw[7:0]];
    fy1_q <= FADE[fyw[7:0]];
  end

  assign h1 = HASH_MUL * (seed_i ^ (mx0_q ^ my0_q));
  assign h2 = HASH_MUL * (seed_i ^ (mx1_q ^ my0_q));
  assign h3 = HASH_MUL * (seed_i ^ (mx0_q ^ my1_q));
  assign h4 = HASH_MUL * (seed_i ^ (mx1_q ^ my1_q));

  always_ff @(posedge clk_i) begin
    z1_q  <= h1[30:7];
    z2_q  <= h2[30:7];
    z3_q  <= h3[30:7];
    z4_q  <= h4[30:7];
    fx2_q <= fx1_q;
    fy2_q <= fy1_q;
  end

  assign fy_inv = FADE_W'(65536) - fy2_q;

  always_ff @(posedge clk_i) begin
    la_q  <= NUM_W'(z1_q) * NUM_W'(fy_inv);
    lb_q  <= NUM_W'(z3_q) * NUM_W'(fy2_q);
    ra_q  <= NUM_W'(z2_q) * NUM_W'(fy_inv);
    rb_q  <= NUM_W'(z4_q) * NUM_W'(fy2_q);
    fx3_q <= fx2_q;
  end

  assign lsum   = {1'b0, la_q} + {1'b0, lb_q};
  assign rsum   = {1'b0, ra_q} + {1'b0, rb_q};
  assign left   = lsum[SUM_W+15:16];
  assign right  = rsum[SUM_W+15:16];
  assign fx_inv = FADE_W'(65536) - fx3_q;

  always_ff @(posedge clk_i) begin
    pl_q <= NUM_W'(left) * NUM_W'(fx_inv);
    pr_q <= NUM_W'(right) * NUM_W'(fx3_q);
  end

  assign bsum    = {1'b0, pl_q} + {1'b0, pr_q};
  assign blended = bsum[SUM_W+15:16];

  // hand the pixel on each cycle; the hash and blend ride alongside
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b1_q.valid <= 1'b0;
      b2_q.valid <= 1'b0;
      b3_q.valid <= 1'b0;
      b4_q.valid <= 1'b0;
      bus_o.valid <= 1'b0;
    end else begin
      b1_q        <= bus_i;
      b2_q        <= b1_q;
      b3_q        <= b2_q;
      b4_q        <= b3_q;
      bus_o.valid <= b4_q.valid;
      bus_o.x     <= b4_q.x;
      bus_o.y     <= b4_q.y;
      // weight the octave by 2^-j, drop it when past the octave count
      bus_o.sum   <= b4_q.sum + (act_q[4] ? (blended >> J) : '0);
    end
  end

  always_ff @(posedge clk_i) begin
    act_q <= {act_q[3:1], active};
  end

endmodule
`default_nettype wire

FILE: src/fvn_div_cell.sv
`default_nettype none
module fvn_div_cell
  import fvn_pkg::*;
#(
  parameter int unsigned BIT = 0
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic [31:0] den_i,
  input  wire fvn_div_t    div_i,
  output fvn_div_t         div_o
);

  logic [NUM_W-1:0] trial;
  logic             take;
  logic [QUO_W-1:0] quo_nx;

  assign trial = NUM_W'(den_i) << BIT;
  assign take  = (div_i.rem >= trial);

  always_comb begin
    quo_nx      = div_i.quo;
    quo_nx[BIT] = take;
  end

  // one restoring quotient bit per cell
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_o.valid <= 1'b0;
    end else begin
      div_o.valid <= div_i.valid;
      div_o.rem   <= take ? div_i.rem - trial : div_i.rem;
      div_o.quo   <= quo_nx;
    end
  end

endmodule
`default_nettype wire
